@@ src/atwd_pkg.sv @@
package atwd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned TABLE_WORDS = 256;
    localparam int unsigned TABLE_AW    = 8;
    localparam int unsigned TABLE_SEGS  = 5;

    localparam logic [WORD_W-1:0] MIX_INIT  = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_ADD   = 32'h1111_1111;
    localparam logic [WORD_W-1:0] MIX_INC   = 32'd3;
    localparam logic [WORD_W-1:0] LCG_START = 32'h0010_0001;
    localparam logic [WORD_W-1:0] LCG_MUL   = 32'd125;
    localparam logic [WORD_W-1:0] LCG_INC   = 32'd3;
    localparam logic [WORD_W-1:0] LCG_MOD   = 32'h002A_AAAB;

    typedef logic [TABLE_WORDS-1:0][WORD_W-1:0] mix_table_t;

    // One step of the table generator. Only evaluated while the constant
    // table below is elaborated.
    function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] s);
        return (s * LCG_MUL + LCG_INC) % LCG_MOD;
    endfunction

    // Each segment of a table word takes two generator steps (high half first);
    // only the last of the five segments is kept.
    function automatic mix_table_t build_mix_table();
        mix_table_t      tbl;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        tbl = '0;
        s   = LCG_START;
        for (int w = 0; w < TABLE_WORDS; w++) begin
            for (int seg = 0; seg < TABLE_SEGS; seg++) begin
                s  = lcg_next(s);
                hi = {s[15:0], 16'h0000};
                s  = lcg_next(s);
                lo = {16'h0000, s[15:0]};
                if (seg == TABLE_SEGS - 1) begin
                    tbl[w] = hi | lo;
                end
            end
        end
        return tbl;
    endfunction

    localparam mix_table_t MIX_TABLE = build_mix_table();

    // Key seed scramble applied after every word.
    function automatic logic [WORD_W-1:0] key_scramble(input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] inv;
        inv = ~k;
        return ((inv << 21) + KEY_ADD) | (k >> 11);
    endfunction

endpackage

@@ src/atwd_ram.sv @@
module atwd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

@@ src/archive_table_word_decrypt_unit.sv @@
// Streaming decryptor for 32-bit archive table words.
// The input channel (s_valid/s_ready) carries one cipher word per transfer,
// with s_start_of_block marking the first word of a block. The result
// channel (m_valid/m_ready) returns exactly one plain word per input
// transfer, in order. The key is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the unit is idle, as the block does
// not enforce this; it is picked up at the next start of block. The
// plain word is presented on the cycle after its input transfer. One
// word is taken per cycle while the receiver does not stall; the seed
// update loop keeps up because the mixing-table entry for the next word
// is fetched ahead (one RAM port follows the running key seed, the other
// follows the key register). After reset the mixing table is copied into
// the RAM, one entry a cycle, followed by a settle state; s_ready stays
// low through both. Seeds and the key return to their reset values.
// When the receiver stalls, the result stays in the output register and
// one more input is only taken once that result is transferred, so a
// stall propagates to s_ready in the same cycle.
module archive_table_word_decrypt_unit
    import atwd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [WORD_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_cipher_word,
    input  logic              s_start_of_block,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_plain_word
);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SETTLE,
        ST_RUN
    } state_t;

    state_t               state_reg;
    logic [TABLE_AW-1:0]  fill_addr_reg;
    logic [WORD_W-1:0]    block_key_reg;
    logic [WORD_W-1:0]    block_key_next;
    logic [WORD_W-1:0]    key_seed_reg;
    logic [WORD_W-1:0]    key_seed_next;
    logic [WORD_W-1:0]    mix_seed_reg;
    logic [WORD_W-1:0]    mix_seed_next;
    logic                 m_valid_reg;
    logic [WORD_W-1:0]    m_plain_word_reg;

    logic                 accept;
    logic                 fill_we;
    logic [WORD_W-1:0]    tbl_seed;
    logic [WORD_W-1:0]    tbl_key;
    logic [WORD_W-1:0]    key_cur;
    logic [WORD_W-1:0]    tbl_cur;
    logic [WORD_W-1:0]    mix_base;
    logic [WORD_W-1:0]    mix_sum;
    logic [WORD_W-1:0]    plain;

    // The table RAM. Port A always holds the entry for the running key seed,
    // port B the entry for the key register, both as of the current cycle.
    assign fill_we = (state_reg == ST_FILL);

    atwd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_mix_ram (
        .aclk      (aclk),
        .wr_en     (fill_we),
        .wr_addr   (fill_addr_reg),
        .wr_data   (MIX_TABLE[fill_addr_reg]),
        .rd_a_addr (key_seed_next[TABLE_AW-1:0]),
        .rd_a_data (tbl_seed),
        .rd_b_addr (block_key_next[TABLE_AW-1:0]),
        .rd_b_data (tbl_key)
    );

    assign s_ready = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign block_key_next = cfg_wr_en ? cfg_wr_data : block_key_reg;

    // A block start replaces both seeds before the word is processed.
    assign key_cur  = s_start_of_block ? block_key_reg : key_seed_reg;
    assign tbl_cur  = s_start_of_block ? tbl_key : tbl_seed;
    assign mix_base = s_start_of_block ? MIX_INIT : mix_seed_reg;

    assign mix_sum = mix_base + tbl_cur;
    assign plain   = s_cipher_word ^ (key_cur + mix_sum);

    always_comb begin
        key_seed_next = key_seed_reg;
        mix_seed_next = mix_seed_reg;
        if (accept) begin
            key_seed_next = key_scramble(key_cur);
            mix_seed_next = plain + mix_sum + (mix_sum << 5) + MIX_INC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            fill_addr_reg <= '0;
            block_key_reg <= '0;
            key_seed_reg  <= '0;
            mix_seed_reg  <= MIX_INIT;
            m_valid_reg   <= 1'b0;
        end else begin
            block_key_reg <= block_key_next;
            key_seed_reg  <= key_seed_next;
            mix_seed_reg  <= mix_seed_next;
            unique case (state_reg)
                ST_FILL: begin
                    fill_addr_reg <= fill_addr_reg + TABLE_AW'(1);
                    if (fill_addr_reg == TABLE_AW'(TABLE_WORDS - 1)) begin
                        state_reg <= ST_SETTLE;
                    end
                end
                ST_SETTLE: begin
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    state_reg <= ST_RUN;
                end
                default: begin
                    state_reg <= ST_FILL;
                end
            endcase
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_plain_word_reg <= plain;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_plain_word = m_plain_word_reg;

`ifndef NO_ASSERTIONS
    // Every accepted word shows up as a result on the next cycle.
    a_accept_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word did not produce a result");

    // The running key seed only moves when a word is transferred.
    a_key_seed_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(key_seed_reg))
        else $error("key seed changed without a transfer");

    // The fill sweep ends after the last table entry is written.
    a_fill_ends : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && fill_addr_reg == TABLE_AW'(TABLE_WORDS - 1))
        |=> (state_reg == ST_SETTLE))
        else $error("table fill did not finish");

    // No input is taken before the table is loaded.
    a_no_accept_in_fill : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !accept)
        else $error("input transfer during table fill");
`endif

endmodule
